### rtl/bpm_pkg.sv
// shared constants, types and helper functions of the point mass integrator
package bpm_pkg;

    localparam int DATA_W       = 32;
    localparam int ANGLE_W      = 19;
    localparam int DRAG_W       = 20;
    localparam int GRAV_W       = 21;
    localparam int DT_W         = 16;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 21;
    localparam int ROUND_SHIFT  = 16;
    localparam int MUL_W        = 33;
    localparam int PROD_W       = 2 * MUL_W;
    localparam int SAT_W        = 56;
    localparam int SQ_W         = 64;
    localparam int ROOT_W       = 32;
    localparam int ROOT_CNT_W   = 5;
    localparam int CORDIC_W     = 36;
    localparam int ZACC_W       = 34;
    localparam int CORDIC_ITERATIONS = 16;
    localparam int ATAN_IDX_W   = 5;
    localparam int CORDIC_CNT_W = $clog2(CORDIC_ITERATIONS);

    localparam logic [GRAV_W-1:0] GRAVITY_RESET = 21'd642688;

    localparam logic [CFG_IDX_W-1:0] REG_DRAG_INDEX = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GRAVITY    = 1'b1;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef logic signed [DATA_W-1:0]  data_t;
    typedef logic signed [ANGLE_W-1:0] angle_t;

    // clamp to the signed 32-bit range
    function automatic data_t sat32(input logic signed [SAT_W-1:0] v);
        if (v > $signed({{(SAT_W-DATA_W){1'b0}}, 1'b0, {(DATA_W-1){1'b1}}}))
            return {1'b0, {(DATA_W-1){1'b1}}};
        else if (v < $signed({{(SAT_W-DATA_W){1'b1}}, 1'b1, {(DATA_W-1){1'b0}}}))
            return {1'b1, {(DATA_W-1){1'b0}}};
        else
            return v[DATA_W-1:0];
    endfunction

    // arctangent of 2^-i in Q2.30 radians
    function automatic logic signed [ZACC_W-1:0] atan_q30(input logic [ATAN_IDX_W-1:0] i);
        logic signed [ZACC_W-1:0] a;
        case (i)
            5'd0:  a = 34'sd843314857;
            5'd1:  a = 34'sd497837829;
            5'd2:  a = 34'sd263043837;
            5'd3:  a = 34'sd133525159;
            5'd4:  a = 34'sd67021687;
            5'd5:  a = 34'sd33543516;
            5'd6:  a = 34'sd16775851;
            5'd7:  a = 34'sd8388437;
            5'd8:  a = 34'sd4194283;
            5'd9:  a = 34'sd2097149;
            5'd10: a = 34'sd1048576;
            5'd11: a = 34'sd524288;
            5'd12: a = 34'sd262144;
            5'd13: a = 34'sd131072;
            5'd14: a = 34'sd65536;
            5'd15: a = 34'sd32768;
            5'd16: a = 34'sd16384;
            5'd17: a = 34'sd8192;
            5'd18: a = 34'sd4096;
            5'd19: a = 34'sd2048;
            5'd20: a = 34'sd1024;
            5'd21: a = 34'sd512;
            5'd22: a = 34'sd256;
            5'd23: a = 34'sd128;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

### rtl/bpm_if.sv
// handshake channels of the point mass integrator: items, results, register writes
interface bpm_item_if;
    import bpm_pkg::*;
    logic                  valid;
    logic                  ready;
    logic                  operation;
    logic [DT_W-1:0]       time_step;
    logic signed [DATA_W-1:0] load_north;
    logic signed [DATA_W-1:0] load_east;
    logic signed [DATA_W-1:0] load_down;
    modport source (output valid, operation, time_step, load_north, load_east, load_down,
                    input ready);
    modport sink   (input valid, operation, time_step, load_north, load_east, load_down,
                    output ready);
endinterface

interface bpm_result_if;
    import bpm_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [DATA_W-1:0]  accel_north;
    logic signed [DATA_W-1:0]  accel_east;
    logic signed [DATA_W-1:0]  accel_down;
    logic signed [DATA_W-1:0]  speed_north;
    logic signed [DATA_W-1:0]  speed_east;
    logic signed [DATA_W-1:0]  speed_down;
    logic [DATA_W-1:0]         total_speed;
    logic [DATA_W-1:0]         ground_speed;
    logic signed [ANGLE_W-1:0] pitch_angle;
    logic signed [ANGLE_W-1:0] heading_angle;
    modport source (output valid, accel_north, accel_east, accel_down, speed_north,
                    speed_east, speed_down, total_speed, ground_speed, pitch_angle,
                    heading_angle, input ready);
    modport sink   (input valid, accel_north, accel_east, accel_down, speed_north,
                    speed_east, speed_down, total_speed, ground_speed, pitch_angle,
                    heading_angle, output ready);
endinterface

interface bpm_cfg_if;
    import bpm_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, reg_index, data, input ready);
    modport sink   (input valid, reg_index, data, output ready);
endinterface

### rtl/bpm_isqrt.sv
// iterative floor square root, one result bit per cycle
module bpm_isqrt (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [bpm_pkg::SQ_W-1:0]  operand,
    output logic                      busy,
    output logic [bpm_pkg::ROOT_W-1:0] root
);
    import bpm_pkg::*;

    logic [SQ_W-1:0]       val_reg;
    logic [ROOT_W+1:0]     rem_reg;
    logic [ROOT_W-1:0]     root_reg;
    logic [ROOT_CNT_W-1:0] cnt_reg;
    logic                  busy_reg;

    logic [ROOT_W+3:0] cand;
    logic [ROOT_W+3:0] trial;
    logic [ROOT_W+3:0] diff;
    logic              fits;

    assign cand  = {rem_reg, val_reg[SQ_W-1 -: 2]};
    assign trial = {2'b00, root_reg, 2'b01};
    assign diff  = cand - trial;
    assign fits  = (cand >= trial);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            val_reg  <= '0;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
            val_reg  <= operand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            val_reg <= {val_reg[SQ_W-3:0], 2'b00};
            if (fits)
            begin
                rem_reg  <= diff[ROOT_W+1:0];
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= cand[ROOT_W+1:0];
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == ROOT_CNT_W'(ROOT_W - 1))
                busy_reg <= 1'b0;
        end
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

### rtl/bpm_cordic.sv
// iterative cordic vectoring unit giving atan2(y, x) in Q3.16 radians
module bpm_cordic (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [bpm_pkg::CORDIC_W-1:0] y_in,
    input  logic signed [bpm_pkg::CORDIC_W-1:0] x_in,
    output logic                               busy,
    output logic signed [bpm_pkg::ANGLE_W-1:0]  angle
);
    import bpm_pkg::*;

    localparam logic signed [ZACC_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [ZACC_W-1:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [ZACC_W-1:0] PI_Q16      = 34'sd205887;

    logic signed [CORDIC_W-1:0] x_reg;
    logic signed [CORDIC_W-1:0] y_reg;
    logic signed [ZACC_W-1:0]   z_reg;
    logic [CORDIC_CNT_W-1:0]    cnt_reg;
    logic                       busy_reg;
    logic                       zero_reg;

    logic signed [CORDIC_W-1:0] xs;
    logic signed [CORDIC_W-1:0] ys;
    logic signed [ZACC_W-1:0]   step_angle;
    logic signed [ZACC_W-1:0]   z_clamp;
    logic signed [ZACC_W-1:0]   z_round;

    assign xs         = x_reg >>> cnt_reg;
    assign ys         = y_reg >>> cnt_reg;
    assign step_angle = atan_q30(ATAN_IDX_W'(cnt_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            zero_reg <= 1'b1;
            cnt_reg  <= '0;
            x_reg    <= '0;
            y_reg    <= '0;
            z_reg    <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
            zero_reg <= (x_in == '0) && (y_in == '0);
            // pre-rotate the left half plane by a quarter turn
            if (x_in < 0)
            begin
                if (y_in >= 0)
                begin
                    x_reg <= y_in;
                    y_reg <= -x_in;
                    z_reg <= HALF_PI_Q30;
                end
                else
                begin
                    x_reg <= -y_in;
                    y_reg <= x_in;
                    z_reg <= -HALF_PI_Q30;
                end
            end
            else
            begin
                x_reg <= x_in;
                y_reg <= y_in;
                z_reg <= '0;
            end
        end
        else if (busy_reg)
        begin
            if (y_reg >= 0)
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + step_angle;
            end
            else
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - step_angle;
            end
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CORDIC_CNT_W'(CORDIC_ITERATIONS - 1))
                busy_reg <= 1'b0;
        end
    end

    // clamp to +-pi, round half up to 16 fraction bits, clamp again
    always_comb
    begin
        z_clamp = z_reg;
        if (z_reg > PI_Q30)
            z_clamp = PI_Q30;
        else if (z_reg < -PI_Q30)
            z_clamp = -PI_Q30;
        z_round = (z_clamp + 34'sd8192) >>> 14;
        if (z_round > PI_Q16)
            z_round = PI_Q16;
        else if (z_round < -PI_Q16)
            z_round = -PI_Q16;
    end

    assign busy  = busy_reg;
    assign angle = zero_reg ? '0 : z_round[ANGLE_W-1:0];

endmodule

### rtl/ballistic_point_mass_step.sv
// top level of the point mass integrator with linear drag
// Each transaction on item either loads the north-east-down velocity or, on a tick, integrates
// one Euler step: acceleration is minus drag_index times velocity (plus gravity on the down
// axis), and velocity grows by acceleration times time_step with 32-bit saturation. Every item
// gives one result transaction with acceleration (zero on load), velocity, total and ground
// speed and the pitch and heading angles in Q3.16 radians. Work runs through one shared
// 33x33 multiplier (multiply, then round and saturate per product), one bit-per-cycle
// square root unit and one cordic unit. A tick runs multiplies for drag and then for
// integration, a load skips them; then come the squares and two rounds of start, root
// iterations and hand-off, the first overlapped with the heading cordic and the second with
// the pitch cordic, and then the output register is loaded. item is not ready until the
// result has been handed to the output register; it is ready again in the cycle the result
// appears, so the next item can be accepted while the result drains. A result that waits in
// the output register holds the block until it is taken. Register writes on cfg are taken
// at any time and are meant for idle.
module ballistic_point_mass_step (
    input  logic clk,
    input  logic rst_n,
    bpm_item_if.sink     item,
    bpm_result_if.source result,
    bpm_cfg_if.sink      cfg
);
    import bpm_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DRAG,
        ST_INTEG,
        ST_SQUARE,
        ST_FIRST_GO,
        ST_FIRST_WAIT,
        ST_SECOND_GO,
        ST_SECOND_WAIT,
        ST_OUT
    } state_t;

    state_t state_reg;

    // configuration registers
    logic [DRAG_W-1:0] drag_reg;
    logic [GRAV_W-1:0] gravity_reg;

    // velocity state and per-item working values
    data_t            vel_reg   [3];
    data_t            accel_reg [3];
    logic [DT_W-1:0]  dt_reg;
    logic [1:0]       axis_reg;
    logic             phase_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [SQ_W-1:0]  sq_h_reg;
    logic [SQ_W-1:0]  sq_t_reg;
    logic [ROOT_W-1:0] ground_reg;
    logic [ROOT_W-1:0] total_reg;
    angle_t           heading_reg;
    angle_t           pitch_reg;

    // output register
    logic   out_valid_reg;
    data_t  out_accel_reg [3];
    data_t  out_speed_reg [3];
    logic [ROOT_W-1:0] out_total_reg;
    logic [ROOT_W-1:0] out_ground_reg;
    angle_t out_pitch_reg;
    angle_t out_heading_reg;

    // shared multiplier
    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] rnd;
    logic signed [PROD_W-1:0] accel_sum;
    logic signed [PROD_W-1:0] vel_sum;
    data_t vel_sel;
    data_t accel_sel;

    // root and angle units
    logic              root_start;
    logic [SQ_W-1:0]   root_operand;
    logic              root_busy;
    logic [ROOT_W-1:0] root_value;
    logic              cordic_start;
    logic signed [CORDIC_W-1:0] cordic_y;
    logic signed [CORDIC_W-1:0] cordic_x;
    logic              cordic_busy;
    angle_t            cordic_angle;

    logic out_free;

    assign vel_sel   = vel_reg[axis_reg];
    assign accel_sel = accel_reg[axis_reg];

    always_comb
    begin
        case (state_reg)
            ST_DRAG:
            begin
                mul_a = MUL_W'(vel_sel);
                mul_b = $signed({{(MUL_W-DRAG_W){1'b0}}, drag_reg});
            end
            ST_INTEG:
            begin
                mul_a = MUL_W'(accel_sel);
                mul_b = $signed({{(MUL_W-DT_W){1'b0}}, dt_reg});
            end
            default:
            begin
                mul_a = MUL_W'(vel_sel);
                mul_b = MUL_W'(vel_sel);
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // round half up at 16 fraction bits
    assign rnd = (prod_reg + PROD_W'(32768)) >>> ROUND_SHIFT;
    assign accel_sum = -rnd + ((axis_reg == 2'd2) ?
                               $signed({{(PROD_W-GRAV_W){1'b0}}, gravity_reg}) : '0);
    assign vel_sum   = PROD_W'(vel_sel) + rnd;

    // unit operands for the two root/angle rounds
    assign root_start   = (state_reg == ST_FIRST_GO) || (state_reg == ST_SECOND_GO);
    assign cordic_start = root_start;
    assign root_operand = (state_reg == ST_FIRST_GO) ? sq_h_reg : sq_t_reg;
    always_comb
    begin
        if (state_reg == ST_FIRST_GO)
        begin
            cordic_y = CORDIC_W'(vel_reg[1]);
            cordic_x = CORDIC_W'(vel_reg[0]);
        end
        else
        begin
            cordic_y = -CORDIC_W'(vel_reg[2]);
            cordic_x = $signed({{(CORDIC_W-ROOT_W){1'b0}}, ground_reg});
        end
    end

    bpm_isqrt u_isqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (root_start),
        .operand (root_operand),
        .busy    (root_busy),
        .root    (root_value)
    );

    bpm_cordic u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cordic_start),
        .y_in  (cordic_y),
        .x_in  (cordic_x),
        .busy  (cordic_busy),
        .angle (cordic_angle)
    );

    assign out_free = !out_valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            drag_reg      <= '0;
            gravity_reg   <= GRAVITY_RESET;
            for (int i = 0; i < 3; i++)
            begin
                vel_reg[i]       <= '0;
                accel_reg[i]     <= '0;
                out_accel_reg[i] <= '0;
                out_speed_reg[i] <= '0;
            end
            dt_reg          <= '0;
            axis_reg        <= '0;
            phase_reg       <= 1'b0;
            prod_reg        <= '0;
            sq_h_reg        <= '0;
            sq_t_reg        <= '0;
            ground_reg      <= '0;
            total_reg       <= '0;
            heading_reg     <= '0;
            pitch_reg       <= '0;
            out_valid_reg   <= 1'b0;
            out_total_reg   <= '0;
            out_ground_reg  <= '0;
            out_pitch_reg   <= '0;
            out_heading_reg <= '0;
        end
        else
        begin
            // register writes
            if (cfg.valid)
            begin
                case (cfg.reg_index)
                    REG_DRAG_INDEX: drag_reg    <= cfg.data[DRAG_W-1:0];
                    REG_GRAVITY:    gravity_reg <= cfg.data[GRAV_W-1:0];
                    default: ;
                endcase
            end

            // output register fills from ST_OUT, empties when taken
            if ((state_reg == ST_OUT) && out_free)
                out_valid_reg <= 1'b1;
            else if (result.valid && result.ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (item.valid)
                    begin
                        axis_reg  <= '0;
                        phase_reg <= 1'b0;
                        dt_reg    <= item.time_step;
                        if (item.operation == OP_LOAD)
                        begin
                            vel_reg[0] <= item.load_north;
                            vel_reg[1] <= item.load_east;
                            vel_reg[2] <= item.load_down;
                            for (int i = 0; i < 3; i++)
                                accel_reg[i] <= '0;
                            state_reg <= ST_SQUARE;
                        end
                        else
                            state_reg <= ST_DRAG;
                    end
                end

                // each axis: multiply, then round and saturate (drag, integration) or accumulate the square
                ST_DRAG, ST_INTEG, ST_SQUARE:
                begin
                    if (!phase_reg)
                    begin
                        prod_reg  <= prod;
                        phase_reg <= 1'b1;
                    end
                    else
                    begin
                        phase_reg <= 1'b0;
                        if (state_reg == ST_DRAG)
                            accel_reg[axis_reg] <= sat32(accel_sum[SAT_W-1:0]);
                        else if (state_reg == ST_INTEG)
                            vel_reg[axis_reg] <= sat32(vel_sum[SAT_W-1:0]);
                        else
                        begin
                            // horizontal sum first, then the total
                            case (axis_reg)
                                2'd0:    sq_h_reg <= prod_reg[SQ_W-1:0];
                                2'd1:    sq_h_reg <= sq_h_reg + prod_reg[SQ_W-1:0];
                                default: sq_t_reg <= sq_h_reg + prod_reg[SQ_W-1:0];
                            endcase
                        end
                        if (axis_reg == 2'd2)
                        begin
                            axis_reg <= '0;
                            case (state_reg)
                                ST_DRAG:  state_reg <= ST_INTEG;
                                ST_INTEG: state_reg <= ST_SQUARE;
                                default:  state_reg <= ST_FIRST_GO;
                            endcase
                        end
                        else
                            axis_reg <= axis_reg + 1'b1;
                    end
                end

                ST_FIRST_GO:
                    state_reg <= ST_FIRST_WAIT;

                // ground speed and heading
                ST_FIRST_WAIT:
                begin
                    if (!root_busy && !cordic_busy)
                    begin
                        ground_reg  <= root_value;
                        heading_reg <= cordic_angle;
                        state_reg   <= ST_SECOND_GO;
                    end
                end

                ST_SECOND_GO:
                    state_reg <= ST_SECOND_WAIT;

                // total speed and pitch
                ST_SECOND_WAIT:
                begin
                    if (!root_busy && !cordic_busy)
                    begin
                        total_reg <= root_value;
                        pitch_reg <= cordic_angle;
                        state_reg <= ST_OUT;
                    end
                end

                ST_OUT:
                begin
                    if (out_free)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            out_accel_reg[i] <= accel_reg[i];
                            out_speed_reg[i] <= vel_reg[i];
                        end
                        out_total_reg   <= total_reg;
                        out_ground_reg  <= ground_reg;
                        out_pitch_reg   <= pitch_reg;
                        out_heading_reg <= heading_reg;
                        state_reg       <= ST_IDLE;
                    end
                end

                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign item.ready = (state_reg == ST_IDLE);
    assign cfg.ready  = 1'b1;

    assign result.valid         = out_valid_reg;
    assign result.accel_north   = out_accel_reg[0];
    assign result.accel_east    = out_accel_reg[1];
    assign result.accel_down    = out_accel_reg[2];
    assign result.speed_north   = out_speed_reg[0];
    assign result.speed_east    = out_speed_reg[1];
    assign result.speed_down    = out_speed_reg[2];
    assign result.total_speed   = out_total_reg;
    assign result.ground_speed  = out_ground_reg;
    assign result.pitch_angle   = out_pitch_reg;
    assign result.heading_angle = out_heading_reg;

endmodule

### sim/tb_ballistic_point_mass_step_sb.sv
// scoreboard class: predicts integrator results and checks them in order
`timescale 1ns / 100ps

package tb_bpm_sb_pkg;
    import bpm_pkg::*;

    typedef struct {
        logic signed [31:0] accel_north;
        logic signed [31:0] accel_east;
        logic signed [31:0] accel_down;
        logic signed [31:0] speed_north;
        logic signed [31:0] speed_east;
        logic signed [31:0] speed_down;
        logic [31:0]        total_speed;
        logic [31:0]        ground_speed;
        logic signed [18:0] pitch_angle;
        logic signed [18:0] heading_angle;
    } motion_t;

    class motion_scoreboard;
        logic [DRAG_W-1:0] drag;
        logic [GRAV_W-1:0] grav;
        longint vn, ve, vd;
        motion_t pending[$];
        int errors;
        int loads, ticks, checked;

        function new();
            drag = '0;
            grav = GRAVITY_RESET;
            vn = 0; ve = 0; vd = 0;
            errors = 0; loads = 0; ticks = 0; checked = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == REG_DRAG_INDEX)
                drag = val[DRAG_W-1:0];
            else if (idx == REG_GRAVITY)
                grav = val[GRAV_W-1:0];
        endfunction

        static function longint clamp32(longint x);
            if (x > 64'sd2147483647) return 64'sd2147483647;
            if (x < -64'sd2147483648) return -64'sd2147483648;
            return x;
        endfunction

        // arithmetic shift is a floor shift on longint
        static function longint round_q16(longint p);
            return (p + 32768) >>> 16;
        endfunction

        static function longint unsigned root_floor(longint unsigned v);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0)
            begin
                if (v >= r + b)
                begin
                    v -= r + b;
                    r = (r >> 1) + b;
                end
                else
                    r >>= 1;
                b >>= 2;
            end
            return r;
        endfunction

        static function longint arctan_q30(int i);
            longint tbl[16] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288,
                262144, 131072, 65536, 32768};
            return tbl[i];
        endfunction

        static function logic signed [18:0] angle_of(longint y, longint x);
            longint z, t, xs, ys;
            z = 0;
            if (x == 0 && y == 0) return '0;
            if (x < 0)
            begin
                t = x;
                if (y >= 0)
                begin
                    x = y; y = -t; z = 64'sd1686629713;
                end
                else
                begin
                    x = -y; y = t; z = -64'sd1686629713;
                end
            end
            for (int i = 0; i < CORDIC_ITERATIONS; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0)
                begin
                    x += ys; y -= xs; z += arctan_q30(i);
                end
                else
                begin
                    x -= ys; y += xs; z -= arctan_q30(i);
                end
            end
            if (z > 64'sd3373259426) z = 64'sd3373259426;
            if (z < -64'sd3373259426) z = -64'sd3373259426;
            z = (z + 8192) >>> 14;
            if (z > 205887) z = 205887;
            if (z < -205887) z = -205887;
            return z[18:0];
        endfunction

        // note one accepted item and queue its expected result
        function void note_item(logic op, logic [15:0] dt, logic signed [31:0] ln,
                                logic signed [31:0] le, logic signed [31:0] ld);
            motion_t m;
            longint an, ae, ad, d, t;
            longint unsigned hsq, gs;
            an = 0; ae = 0; ad = 0;
            if (op == OP_LOAD)
            begin
                vn = longint'(ln); ve = longint'(le); vd = longint'(ld);
                loads++;
            end
            else
            begin
                d = longint'(drag);
                t = longint'(dt);
                an = clamp32(-round_q16(vn * d));
                ae = clamp32(-round_q16(ve * d));
                ad = clamp32(-round_q16(vd * d) + longint'(grav));
                vn = clamp32(vn + round_q16(an * t));
                ve = clamp32(ve + round_q16(ae * t));
                vd = clamp32(vd + round_q16(ad * t));
                ticks++;
            end
            hsq = longint'(vn * vn) + longint'(ve * ve);
            gs = root_floor(hsq);
            m.total_speed = 32'(root_floor(hsq + longint'(vd * vd)));
            m.ground_speed = 32'(gs);
            m.accel_north = 32'(an); m.accel_east = 32'(ae); m.accel_down = 32'(ad);
            m.speed_north = 32'(vn); m.speed_east = 32'(ve); m.speed_down = 32'(vd);
            m.pitch_angle = angle_of(-vd, longint'(gs));
            m.heading_angle = angle_of(ve, vn);
            pending.push_back(m);
        endfunction

        function void check_result(motion_t got);
            motion_t want;
            if (pending.size() == 0)
            begin
                $error("result transaction with nothing expected");
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.accel_north !== want.accel_north)
                begin $error("accel_north exp %0d got %0d", want.accel_north, got.accel_north); errors++; end
            if (got.accel_east !== want.accel_east)
                begin $error("accel_east exp %0d got %0d", want.accel_east, got.accel_east); errors++; end
            if (got.accel_down !== want.accel_down)
                begin $error("accel_down exp %0d got %0d", want.accel_down, got.accel_down); errors++; end
            if (got.speed_north !== want.speed_north)
                begin $error("speed_north exp %0d got %0d", want.speed_north, got.speed_north); errors++; end
            if (got.speed_east !== want.speed_east)
                begin $error("speed_east exp %0d got %0d", want.speed_east, got.speed_east); errors++; end
            if (got.speed_down !== want.speed_down)
                begin $error("speed_down exp %0d got %0d", want.speed_down, got.speed_down); errors++; end
            if (got.total_speed !== want.total_speed)
                begin $error("total_speed exp %0d got %0d", want.total_speed, got.total_speed); errors++; end
            if (got.ground_speed !== want.ground_speed)
                begin $error("ground_speed exp %0d got %0d", want.ground_speed, got.ground_speed); errors++; end
            if (got.pitch_angle !== want.pitch_angle)
                begin $error("pitch_angle exp %0d got %0d", want.pitch_angle, got.pitch_angle); errors++; end
            if (got.heading_angle !== want.heading_angle)
                begin $error("heading_angle exp %0d got %0d", want.heading_angle, got.heading_angle); errors++; end
        endfunction
    endclass
endpackage

### sim/tb_ballistic_point_mass_step.sv
// testbench top: directed and random load/tick items against a scoreboard model
`timescale 1ns / 100ps

module tb_ballistic_point_mass_step;
    import bpm_pkg::*;
    import tb_bpm_sb_pkg::*;

    localparam int RANDOM_ITEMS = 2000;
    localparam int DRAIN_CYCLES = 200;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    bpm_item_if   item_ch();
    bpm_result_if result_ch();
    bpm_cfg_if    cfg_ch();

    motion_scoreboard sb;
    bit timed_out = 1'b0;

    ballistic_point_mass_step u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch.sink),
        .result (result_ch.source),
        .cfg    (cfg_ch.sink)
    );

    always #2 clk = ~clk;

    // all block inputs known from time zero
    initial
    begin
        item_ch.valid = 1'b0;
        item_ch.operation = OP_LOAD;
        item_ch.time_step = '0;
        item_ch.load_north = '0;
        item_ch.load_east = '0;
        item_ch.load_down = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.reg_index = REG_DRAG_INDEX;
        cfg_ch.data = '0;
        result_ch.ready = 1'b0;
    end

    // receiver: stall pattern alternates between busy phases and free-running phases
    initial
    begin
        int phase;
        phase = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            phase = (phase + 1) % 400;
            if (phase < 150)
                result_ch.ready <= 1'b1;
            else
                result_ch.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // result monitor: sample at the edge and check right away
    always @(posedge clk)
    begin
        motion_t got;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got.accel_north = result_ch.accel_north;
            got.accel_east = result_ch.accel_east;
            got.accel_down = result_ch.accel_down;
            got.speed_north = result_ch.speed_north;
            got.speed_east = result_ch.speed_east;
            got.speed_down = result_ch.speed_down;
            got.total_speed = result_ch.total_speed;
            got.ground_speed = result_ch.ground_speed;
            got.pitch_angle = result_ch.pitch_angle;
            got.heading_angle = result_ch.heading_angle;
            sb.check_result(got);
        end
    end

    // burst/gap shaping for the sender
    int burst_left = 0;

    // valid stays up inside a burst; it drops only for a gap or when the sender goes idle
    task automatic send_item(logic op, logic [15:0] dt, logic signed [31:0] ln,
                             logic signed [31:0] le, logic signed [31:0] ld);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 1) ? $urandom_range(1, 40) : 0;
            if (gap != 0)
            begin
                item_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        item_ch.valid <= 1'b1;
        item_ch.operation <= op;
        item_ch.time_step <= dt;
        item_ch.load_north <= ln;
        item_ch.load_east <= le;
        item_ch.load_down <= ld;
        do
            @(posedge clk);
        while (!item_ch.ready);
        sb.note_item(op, dt, ln, le, ld);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.reg_index <= idx;
        cfg_ch.data <= val;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        sb.write_reg(idx, val);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // registers change only once the block has gone quiet
    task automatic wait_idle();
        item_ch.valid <= 1'b0;
        burst_left = 0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic signed [31:0] rand_speed();
        case ($urandom_range(0, 5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return '0;
            3: return $urandom;
            default: return $signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000;
        endcase
    endfunction

    task automatic random_phase(int count);
        for (int i = 0; i < count; i++)
        begin
            // mostly ticks after an occasional reload, all fields random
            if ($urandom_range(0, 7) == 0)
                send_item(OP_LOAD, 16'($urandom), rand_speed(), rand_speed(), rand_speed());
            else
                send_item(OP_TICK, 16'($urandom), $urandom, $urandom, $urandom);
        end
    endtask

    initial
    begin
        sb = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: defaults, zero vector, extremes, negative x for the heading angle
        send_item(OP_TICK, 16'h0000, '0, '0, '0);
        send_item(OP_LOAD, 16'hffff, '0, '0, '0);
        send_item(OP_TICK, 16'hffff, 32'sh7fffffff, 32'sh80000000, 32'sh12345678);
        send_item(OP_LOAD, 16'h0, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
        send_item(OP_TICK, 16'hffff, '0, '0, '0);
        send_item(OP_LOAD, 16'h0, 32'sh80000000, 32'sh80000000, 32'sh80000000);
        send_item(OP_TICK, 16'hffff, '0, '0, '0);
        send_item(OP_LOAD, 16'h0, -32'sh10000, 32'sh10000, -32'sh20000);
        send_item(OP_LOAD, 16'h0, -32'sh10000, -32'sh10000, 32'sh20000);
        send_item(OP_LOAD, 16'h0, -32'sh10000, 32'sh0, 32'sh0);
        send_item(OP_LOAD, 16'h0, 32'sh0, 32'sh0, -32'sh30000);
        send_item(OP_TICK, 16'h8000, '1, '1, '1);
        wait_idle();

        write_reg(REG_DRAG_INDEX, 21'hfffff);
        write_reg(REG_GRAVITY, 21'h1fffff);
        send_item(OP_LOAD, 16'h0, 32'sh7fffffff, 32'sh80000000, 32'sh80000000);
        send_item(OP_TICK, 16'hffff, '0, '0, '0);
        send_item(OP_TICK, 16'h0001, '0, '0, '0);
        random_phase(RANDOM_ITEMS / 4);
        wait_idle();

        write_reg(REG_DRAG_INDEX, 21'h0);
        write_reg(REG_GRAVITY, 21'h0);
        random_phase(RANDOM_ITEMS / 4);
        wait_idle();

        // index bit patterns and an unused data bit above the drag register width
        write_reg(REG_DRAG_INDEX, 21'h1aaaaa);
        write_reg(REG_GRAVITY, 21'h155555);
        random_phase(RANDOM_ITEMS / 4);
        wait_idle();

        write_reg(REG_DRAG_INDEX, 21'($urandom_range(0, 21'hfffff)));
        write_reg(REG_GRAVITY, GRAVITY_RESET);
        random_phase(RANDOM_ITEMS / 4);
        wait_idle();

        $display("covered %0d loads and %0d ticks, %0d results checked",
                 sb.loads, sb.ticks, sb.checked);
        $display("over five register settings with bursty input and a stalling receiver");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // watchdog: a bound on the whole run of about 2000 items, with a wide margin
    initial
    begin
        #20000000;
        timed_out = 1'b1;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule
